// File: design/xs64b_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xs64b_pkg
// Shared types and constants for the xorshift64* bounded random generator.
// ----------------------------------------------------------------------------
package xs64b_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = 32;
  localparam int unsigned MODE_W = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [HALF_W-1:0] half_t;
  typedef logic [MODE_W-1:0] mode_t;

  // request modes
  localparam mode_t MODE_RAW   = 2'd0;
  localparam mode_t MODE_BELOW = 2'd1;
  localparam mode_t MODE_PAGE  = 2'd2;
  localparam mode_t MODE_NONE  = 2'd3;

  // generator constants
  localparam word_t GOLDEN_MIX = 64'h9E37_79B9_7F4A_7C15;
  localparam word_t ZERO_SUBST = 64'hD1B5_4A32_D192_ED03;
  localparam word_t STAR_MULT  = 64'h2545_F491_4F6C_DD1D;

  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned SHIFT_A    = 12;
  localparam int unsigned SHIFT_B    = 25;
  localparam int unsigned SHIFT_C    = 27;

  // start and completion handshake of a shared arithmetic unit
  typedef struct packed {
    logic start;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// File: design/xs64b_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xs64b_req_if
// Request channel: mode and bound with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface xs64b_req_if;
  logic               valid;
  logic               ready;
  xs64b_pkg::mode_t   mode;
  xs64b_pkg::word_t   bound;

  modport source (output valid, output mode, output bound, input ready);
  modport sink   (input valid, input mode, input bound, output ready);
endinterface

// File: design/xs64b_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xs64b_rsp_if
// Result channel: one 64-bit value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface xs64b_rsp_if;
  logic             valid;
  logic             ready;
  xs64b_pkg::word_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// File: design/xorshift64star_bounded_random.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xorshift64star_bounded_random
// Xorshift64* generator returning raw, bounded or page-aligned draws.
// ----------------------------------------------------------------------------
// A request is taken only while the sequencer is idle and then runs to its
// end: a raw draw takes one xorshift step, then four steps of the shared
// 32x32 multiplier; a bounded or page-aligned draw then also runs every
// dividend bit through the one-bit-per-cycle remainder unit; and a request
// that draws nothing (zero bound, bound under one page, unused mode) skips both units.
// The result sits in an output register, so the next request can be taken
// while it waits. The seed is mixed in on the first request that draws;
// later seed writes do not touch the running generator.
module xorshift64star_bounded_random (
  input  logic                 clk,
  input  logic                 rst_n,
  xs64b_req_if.sink            in_ch,
  xs64b_rsp_if.source          out_ch,
  input  logic                 cfg_wr_en,
  input  xs64b_pkg::word_t     cfg_wr_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SHIFT = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_MOD   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]       state_r,   state_nxt;
  logic             seeded_r,  seeded_nxt;
  xs64b_pkg::word_t gen_r,     gen_nxt;
  xs64b_pkg::word_t seed_r;
  xs64b_pkg::mode_t mode_r,    mode_nxt;
  xs64b_pkg::word_t bound_r,   bound_nxt;
  xs64b_pkg::word_t result_r,  result_nxt;
  logic             out_valid_r, out_valid_nxt;
  xs64b_pkg::word_t out_value_r, out_value_nxt;

  xs64b_pkg::unit_ctl_t mul_ctl, mod_ctl;
  xs64b_pkg::unit_sts_t mul_sts, mod_sts;
  xs64b_pkg::word_t     mul_prod, mod_rem, mod_divisor;
  xs64b_pkg::word_t     seed_word, mixed, shifted;
  logic                 in_fire, trivial, out_free;

  function automatic xs64b_pkg::word_t xs_step(input xs64b_pkg::word_t x);
    xs64b_pkg::word_t t;
    t = x ^ (x >> xs64b_pkg::SHIFT_A);
    t = t ^ (t << xs64b_pkg::SHIFT_B);
    t = t ^ (t >> xs64b_pkg::SHIFT_C);
    return t;
  endfunction

  // handshake
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.value = out_value_r;
  assign out_free     = !out_valid_r || out_ch.ready;

  // requests that give zero without drawing
  assign trivial = (in_ch.mode == xs64b_pkg::MODE_NONE)
                || (in_ch.mode == xs64b_pkg::MODE_BELOW && in_ch.bound == '0)
                || (in_ch.mode == xs64b_pkg::MODE_PAGE
                    && in_ch.bound[xs64b_pkg::WORD_W-1:xs64b_pkg::PAGE_SHIFT] == '0);

  // lazy seeding
  assign mixed     = seed_r ^ xs64b_pkg::GOLDEN_MIX;
  assign seed_word = (mixed == '0) ? xs64b_pkg::ZERO_SUBST : mixed;
  assign shifted   = xs_step(gen_r);

  // divisor: bound itself or page count
  assign mod_divisor = (mode_r == xs64b_pkg::MODE_PAGE)
                     ? (bound_r >> xs64b_pkg::PAGE_SHIFT) : bound_r;

  assign mul_ctl.start = (state_r == ST_SHIFT);
  assign mod_ctl.start = (state_r == ST_MUL) && mul_sts.done
                      && (mode_r != xs64b_pkg::MODE_RAW);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    seeded_nxt    = seeded_r;
    gen_nxt       = gen_r;
    mode_nxt      = mode_r;
    bound_nxt     = bound_r;
    result_nxt    = result_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          mode_nxt  = in_ch.mode;
          bound_nxt = in_ch.bound;
          if (trivial) begin
            result_nxt = '0;
            state_nxt  = ST_FIN;
          end else begin
            if (!seeded_r) begin
              gen_nxt    = seed_word;
              seeded_nxt = 1'b1;
            end
            state_nxt = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        gen_nxt   = shifted;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mul_sts.done) begin
          if (mode_r == xs64b_pkg::MODE_RAW) begin
            result_nxt = mul_prod;
            state_nxt  = ST_FIN;
          end else begin
            state_nxt = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (mod_sts.done) begin
          if (mode_r == xs64b_pkg::MODE_PAGE) begin
            result_nxt = mod_rem << xs64b_pkg::PAGE_SHIFT;
          end else begin
            result_nxt = mod_rem;
          end
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = result_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seeded_r    <= 1'b0;
      gen_r       <= '0;
      seed_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seeded_r    <= seeded_nxt;
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    bound_r     <= bound_nxt;
    result_r    <= result_nxt;
    out_value_r <= out_value_nxt;
  end

  xs64b_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mul_ctl),
    .opa     (shifted),
    .sts     (mul_sts),
    .product (mul_prod)
  );

  xs64b_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mod_ctl),
    .dividend  (mul_prod),
    .divisor   (mod_divisor),
    .sts       (mod_sts),
    .remainder (mod_rem)
  );

  // once seeded the generator stays seeded
  a_seeded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    seeded_r |=> seeded_r)
    else $error("seeded flag dropped");

  // a request that draws nothing leaves the generator alone
  a_trivial_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && trivial) |=> $stable(gen_r) && $stable(seeded_r))
    else $error("trivial request touched generator");

  // unit completions only where the sequencer waits for them
  a_mul_done_place: assert property (@(posedge clk) disable iff (!rst_n)
    mul_sts.done |-> state_r == ST_MUL)
    else $error("multiplier done outside wait state");

  a_mod_done_place: assert property (@(posedge clk) disable iff (!rst_n)
    mod_sts.done |-> state_r == ST_MOD)
    else $error("remainder unit done outside wait state");

  // the two shared units never run at the same time
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_sts.busy && mod_sts.busy))
    else $error("multiplier and remainder unit busy together");

  // a bounded draw is below its bound
  a_below_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && mode_r == xs64b_pkg::MODE_BELOW && bound_r != '0)
      |-> result_r < bound_r)
    else $error("bounded result not below bound");

endmodule

// File: design/xs64b_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xs64b_mul
// Low 64 bits of operand times STAR_MULT, built from three 32x32 partial
// products on one shared multiplier, one product per cycle.
// ----------------------------------------------------------------------------
module xs64b_mul (
  input  logic                    clk,
  input  logic                    rst_n,
  input  xs64b_pkg::unit_ctl_t    ctl,
  input  xs64b_pkg::word_t        opa,
  output xs64b_pkg::unit_sts_t    sts,
  output xs64b_pkg::word_t        product
);

  xs64b_pkg::word_t a_r;
  xs64b_pkg::word_t acc_r;
  xs64b_pkg::word_t pp_r;
  logic [1:0]       step_r;
  logic             busy_r;
  logic             done_r;

  xs64b_pkg::half_t mul_a;
  xs64b_pkg::half_t mul_b;
  xs64b_pkg::word_t mul_p;
  xs64b_pkg::word_t acc_add;

  // operand select: lo*lo, lo*hi, hi*lo
  always_comb begin
    mul_a = a_r[xs64b_pkg::HALF_W-1:0];
    mul_b = xs64b_pkg::STAR_MULT[xs64b_pkg::HALF_W-1:0];
    case (step_r)
      2'd1: begin
        mul_b = xs64b_pkg::STAR_MULT[xs64b_pkg::WORD_W-1:xs64b_pkg::HALF_W];
      end
      2'd2: begin
        mul_a = a_r[xs64b_pkg::WORD_W-1:xs64b_pkg::HALF_W];
      end
      default: begin
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // first product lands as is, cross products shifted into the upper half
  assign acc_add = (step_r == 2'd1) ? pp_r
                 : {pp_r[xs64b_pkg::HALF_W-1:0], {xs64b_pkg::HALF_W{1'b0}}};

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r   <= opa;
      acc_r <= '0;
    end else if (busy_r) begin
      pp_r <= mul_p;
      if (step_r != 2'd0) begin
        acc_r <= acc_r + acc_add;
      end
    end
  end

  // step sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        step_r <= 2'd0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign product  = acc_r;

endmodule

// File: design/xs64b_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xs64b_mod
// Restoring remainder unit: one dividend bit per cycle through a shared
// 65-bit compare and subtract. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module xs64b_mod (
  input  logic                    clk,
  input  logic                    rst_n,
  input  xs64b_pkg::unit_ctl_t    ctl,
  input  xs64b_pkg::word_t        dividend,
  input  xs64b_pkg::word_t        divisor,
  output xs64b_pkg::unit_sts_t    sts,
  output xs64b_pkg::word_t        remainder
);

  localparam int unsigned CNT_W = $clog2(xs64b_pkg::WORD_W);

  xs64b_pkg::word_t   dvd_r;
  xs64b_pkg::word_t   dvs_r;
  xs64b_pkg::word_t   rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [xs64b_pkg::WORD_W:0] trial;
  logic [xs64b_pkg::WORD_W:0] diff;

  // shift in next dividend bit, subtract when it fits
  assign trial = {rem_r, dvd_r[xs64b_pkg::WORD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[xs64b_pkg::WORD_W-2:0], 1'b0};
      if (diff[xs64b_pkg::WORD_W]) begin
        rem_r <= trial[xs64b_pkg::WORD_W-1:0];
      end else begin
        rem_r <= diff[xs64b_pkg::WORD_W-1:0];
      end
    end
  end

  // iteration counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == {CNT_W{1'b1}}) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign remainder = rem_r;

endmodule
